@@ rtl/dbrms_pkg.sv @@
// Package for the dual block RMS meter: constants, payload and record types,
// and the arithmetic helpers used by the front end and the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dbrms_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int RMS_BITS      = 23;
  localparam int SUM_BITS      = 62;
  localparam int COUNT_BITS    = 16;
  localparam int SQ_BITS       = 2 * SAMPLE_BITS;
  localparam int ROOT_BITS     = SUM_BITS / 2;
  localparam int DIV_STEPS     = SUM_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_BITS     = 2;
  localparam int DATA_BITS     = 32;

  // Alignment of the integer root (SAMPLE_BITS - 1 magnitude bits) to RMS_BITS.
  localparam int RMS_SHL = (SAMPLE_BITS - 1 < RMS_BITS) ? RMS_BITS - (SAMPLE_BITS - 1) : 0;
  localparam int RMS_SHR = (SAMPLE_BITS - 1 > RMS_BITS) ? (SAMPLE_BITS - 1) - RMS_BITS : 0;

  localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(4800);
  localparam logic [RMS_BITS-1:0]   RMS_LIMIT    = '1;
  localparam logic [SUM_BITS-1:0]   SUM_LIMIT    = '1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic signed [SAMPLE_BITS-1:0] out_sample;
  } frame_t;

  typedef struct packed {
    logic [RMS_BITS-1:0] in_rms;
    logic [RMS_BITS-1:0] out_rms;
  } result_t;

  // One finished window: both sums and the number of frames taken.
  typedef struct packed {
    logic [SUM_BITS-1:0]   in_sum;
    logic [SUM_BITS-1:0]   out_sum;
    logic [COUNT_BITS-1:0] frames;
  } window_t;

  // Magnitude of a two's complement sample; full-scale negative fits unsigned.
  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
    return s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
  endfunction

  function automatic logic [SUM_BITS-1:0] add_sat(input logic [SUM_BITS-1:0] sum,
                                                  input logic [SQ_BITS-1:0] sq);
    logic [SUM_BITS:0] total;
    total = {1'b0, sum} + (SUM_BITS + 1)'(sq);
    return total[SUM_BITS] ? SUM_LIMIT : total[SUM_BITS-1:0];
  endfunction

  function automatic logic [RMS_BITS-1:0] scale_root(input logic [ROOT_BITS-1:0] root);
    logic [63:0] wide;
    wide = (64'(root) << RMS_SHL) >> RMS_SHR;
    return (wide > 64'(RMS_LIMIT)) ? RMS_LIMIT : wide[RMS_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/dual_block_rms_meter.sv @@
// Dual block RMS meter. Each accepted frame carries one input-side and one
// output-side signed sample; both are squared and summed, and after
// window_length frames (0 acts as 1) one result gives floor(sqrt(sum/frames))
// for each side as unsigned Q0.23, saturated at the top code. Frames are taken
// one per clock while full is low: the square of a frame is registered and
// then added to the sums. Each finished window goes into a two-entry record
// queue, and a shared divide-and-root unit turns it into a result: restoring
// division (one quotient bit per cycle, both sides in parallel), bit-serial
// square root, and hand-over (square, record write, load, output register).
// full rises only when the next frame would end a window while the record
// queue has no free slot, counting a window still in flight, which happens
// with windows shorter than the back end's work per window or when results
// are left waiting on the output. There is no clearing pass after reset.
// Depends on dbrms_pkg, dbrms_front, dbrms_fifo and dbrms_back.
`timescale 1ns / 1ps
`default_nettype none
module dual_block_rms_meter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dbrms_pkg::ADDR_BITS-1:0]     paddr,
  input  wire logic [dbrms_pkg::DATA_BITS-1:0]     pwdata,
  output logic      [dbrms_pkg::DATA_BITS-1:0]     prdata,
  output logic                                     pready,
  // Frame requests in.
  input  wire logic                                push,
  input  wire dbrms_pkg::frame_t                   frame,
  output logic                                     full,
  // Result requests out.
  input  wire logic                                pop,
  output dbrms_pkg::result_t                       result,
  output logic                                     empty
);
  import dbrms_pkg::*;

  logic [COUNT_BITS-1:0]    window_length;
  logic                     cfg_write;
  logic                     rec_push;
  window_t                  rec_in;
  window_t                  rec_out;
  logic                     rec_empty;
  logic                     rec_pop;
  logic [FIFO_CNT_BITS-1:0] rec_count;

  // The only register, window_length, occupies the whole address space, so
  // every completed write lands in it. Only its low 16 bits are stored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = DATA_BITS'(window_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_write) begin
      window_length <= pwdata[COUNT_BITS-1:0];
    end
  end

  // Front end: squares and sums, one frame per cycle while full is low.
  dbrms_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .frame         (frame),
    .full          (full),
    .window_length (window_length),
    .fifo_count    (rec_count),
    .rec_push      (rec_push),
    .rec           (rec_in)
  );

  // Finished windows wait here while the back end is busy.
  dbrms_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (rec_push),
    .din   (rec_in),
    .pop   (rec_pop),
    .dout  (rec_out),
    .empty (rec_empty),
    .count (rec_count)
  );

  // Back end: divide, root, and the output register.
  dbrms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec_out),
    .rec_empty (rec_empty),
    .rec_pop   (rec_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire

@@ rtl/dbrms_front.sv @@
// Front end of the RMS meter: takes frames, squares both samples, keeps the
// running sums and hands each finished window to the record queue. Uses dbrms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbrms_front (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     push,
  input  wire dbrms_pkg::frame_t                        frame,
  output logic                                          full,
  input  wire logic [dbrms_pkg::COUNT_BITS-1:0]         window_length,
  input  wire logic [dbrms_pkg::FIFO_CNT_BITS-1:0]      fifo_count,
  output logic                                          rec_push,
  output dbrms_pkg::window_t                            rec
);
  import dbrms_pkg::*;

  logic [COUNT_BITS-1:0]    frame_count;
  logic [COUNT_BITS-1:0]    target;
  logic [COUNT_BITS:0]      taken;
  logic                     is_last;
  logic                     accept;
  logic [FIFO_CNT_BITS:0]   queued;

  logic                     sq_valid;
  logic                     sq_last;
  logic [SQ_BITS-1:0]       sq_in;
  logic [SQ_BITS-1:0]       sq_out;
  logic [COUNT_BITS-1:0]    sq_frames;

  logic [SUM_BITS-1:0]      in_sum;
  logic [SUM_BITS-1:0]      out_sum;
  logic [SUM_BITS-1:0]      in_total;
  logic [SUM_BITS-1:0]      out_total;
  logic [SAMPLE_BITS-1:0]   in_mag;
  logic [SAMPLE_BITS-1:0]   out_mag;

  assign target  = (window_length == '0) ? COUNT_BITS'(1) : window_length;
  assign taken   = {1'b0, frame_count} + (COUNT_BITS + 1)'(1);
  assign is_last = taken >= {1'b0, target};

  // A window-ending frame needs a free queue slot, counting one still in flight.
  assign queued = {1'b0, fifo_count} + (FIFO_CNT_BITS + 1)'(sq_valid && sq_last);
  assign full   = is_last && (queued >= (FIFO_CNT_BITS + 1)'(FIFO_DEPTH));
  assign accept = push && !full;

  assign in_mag  = magnitude(frame.in_sample);
  assign out_mag = magnitude(frame.out_sample);

  assign in_total  = add_sat(in_sum, sq_in);
  assign out_total = add_sat(out_sum, sq_out);

  assign rec_push    = sq_valid && sq_last;
  assign rec.in_sum  = in_total;
  assign rec.out_sum = out_total;
  assign rec.frames  = sq_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      sq_valid    <= 1'b0;
      in_sum      <= '0;
      out_sum     <= '0;
    end else begin
      sq_valid <= accept;
      if (accept) begin
        frame_count <= is_last ? '0 : taken[COUNT_BITS-1:0];
      end
      if (sq_valid) begin
        if (sq_last) begin
          in_sum  <= '0;
          out_sum <= '0;
        end else begin
          in_sum  <= in_total;
          out_sum <= out_total;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_in     <= in_mag * in_mag;
      sq_out    <= out_mag * out_mag;
      sq_last   <= is_last;
      sq_frames <= taken[COUNT_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/dbrms_fifo.sv @@
// Short record queue between the front end and the back end of the RMS meter.
// Uses dbrms_pkg for the record type and depth.
`timescale 1ns / 1ps
`default_nettype none
module dbrms_fifo (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  input  wire dbrms_pkg::window_t                  din,
  input  wire logic                                pop,
  output dbrms_pkg::window_t                       dout,
  output logic                                     empty,
  output logic [dbrms_pkg::FIFO_CNT_BITS-1:0]      count
);
  import dbrms_pkg::*;

  window_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic                     do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign dout   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dbrms_back.sv @@
// Back end of the RMS meter: divides both window sums by the frame count
// one quotient bit per cycle, takes both integer roots one result bit per
// cycle, and holds the result for the consumer. Uses dbrms_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbrms_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dbrms_pkg::window_t  rec,
  input  wire logic                rec_empty,
  output logic                     rec_pop,
  output dbrms_pkg::result_t       result,
  output logic                     empty,
  input  wire logic                pop
);
  import dbrms_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]               state;
  logic [DIV_CNT_BITS-1:0]  step;
  logic [COUNT_BITS-1:0]    divisor;
  logic [SUM_BITS-1:0]      bit_mask;

  // Lane 0 is the input side, lane 1 the output side.
  logic [1:0][SUM_BITS-1:0]   x;
  logic [1:0][COUNT_BITS-1:0] rem;
  logic [1:0][SUM_BITS-1:0]   root;

  logic [1:0][SUM_BITS-1:0]   x_div_next;
  logic [1:0][COUNT_BITS-1:0] rem_next;
  logic [1:0][SUM_BITS-1:0]   x_root_next;
  logic [1:0][SUM_BITS-1:0]   root_next;
  logic [1:0][COUNT_BITS:0]   div_trial;
  logic [1:0][SUM_BITS:0]     root_trial;
  logic [1:0]                 div_ge;
  logic [1:0]                 root_ge;

  logic    out_valid;
  logic    load_out;
  result_t res_next;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      // Restoring division: the quotient bits shift into x behind the dividend.
      div_trial[i]  = {rem[i], x[i][SUM_BITS-1]};
      div_ge[i]     = div_trial[i] >= {1'b0, divisor};
      rem_next[i]   = div_ge[i] ? COUNT_BITS'(div_trial[i] - {1'b0, divisor})
                                : div_trial[i][COUNT_BITS-1:0];
      x_div_next[i] = {x[i][SUM_BITS-2:0], div_ge[i]};

      root_trial[i]  = {1'b0, root[i]} + {1'b0, bit_mask};
      root_ge[i]     = {1'b0, x[i]} >= root_trial[i];
      x_root_next[i] = root_ge[i] ? x[i] - root_trial[i][SUM_BITS-1:0] : x[i];
      root_next[i]   = root_ge[i] ? (root[i] >> 1) + bit_mask : root[i] >> 1;
    end
  end

  assign res_next.in_rms  = scale_root(root[0][ROOT_BITS-1:0]);
  assign res_next.out_rms = scale_root(root[1][ROOT_BITS-1:0]);

  assign rec_pop  = (state == ST_IDLE) && !rec_empty;
  assign load_out = (state == ST_DONE) && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!rec_empty) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (bit_mask[0]) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x[0]    <= rec.in_sum;
        x[1]    <= rec.out_sum;
        rem     <= '0;
        divisor <= rec.frames;
        step    <= '0;
      end
      ST_DIV: begin
        x        <= x_div_next;
        rem      <= rem_next;
        step     <= step + 1'b1;
        root     <= '0;
        bit_mask <= SUM_BITS'(1) << (SUM_BITS - 2);
      end
      ST_ROOT: begin
        x        <= x_root_next;
        root     <= root_next;
        bit_mask <= bit_mask >> 2;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dbrms_checker.sv @@
// Port-level checks for the dual block RMS meter, bound to its top level.
// Uses dbrms_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
module dbrms_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dbrms_pkg::ADDR_BITS-1:0]     paddr,
  input  wire logic [dbrms_pkg::DATA_BITS-1:0]     pwdata,
  input  wire logic [dbrms_pkg::DATA_BITS-1:0]     prdata,
  input  wire logic                                pready,
  input  wire logic                                push,
  input  wire dbrms_pkg::frame_t                   frame,
  input  wire logic                                full,
  input  wire logic                                pop,
  input  wire dbrms_pkg::result_t                  result,
  input  wire logic                                empty
);
  import dbrms_pkg::*;

  logic [31:0] frames_seen;
  logic [31:0] results_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen  <= '0;
      results_seen <= '0;
    end else begin
      frames_seen  <= frames_seen + 32'(push && !full);
      results_seen <= results_seen + 32'(pop && !empty);
    end
  end

  // Reset leaves no result waiting and room for frames.
  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not empty or full after reset");

  // A waiting result stays put until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  // Every window holds at least one frame, so results never outnumber frames.
  assert property (@(posedge clk) disable iff (rst)
    (results_seen + 32'(!empty)) <= frames_seen)
    else $error("more results than frames");

  // A written window length reads back.
  assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready) |=>
      (prdata[COUNT_BITS-1:0] == $past(pwdata[COUNT_BITS-1:0])))
    else $error("window length read back wrong");

endmodule

bind dual_block_rms_meter dbrms_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata),
  .pready  (pready),
  .push    (push),
  .frame   (frame),
  .full    (full),
  .pop     (pop),
  .result  (result),
  .empty   (empty)
);
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the dual block RMS meter: frame requests in,
// paired RMS level results out, window length set over the APB port.
// Depends on dbrms_pkg and the dual_block_rms_meter RTL.
`timescale 1ns / 1ps
module testbench;
  import dbrms_pkg::*;

  // Clock, reset length and the limits of the run.
  localparam int CLK_HIGH_NS   = 6;
  localparam int CLK_LOW_NS    = 6;
  localparam int RESET_CYCLES  = 10;
  // Quiet cycles after the last owed result, enough for the back end to run dry.
  localparam int DRAIN_CYCLES  = 160;
  localparam int RANDOM_FRAMES = 1100;
  localparam int TAIL_FRAMES   = 150;
  localparam int MAX_REPORTS   = 10;
  // Run limit in nanoseconds: several times the slowest legal run.
  localparam longint RUN_LIMIT_NS = 64'd9_600_000;

  localparam logic [ADDR_BITS-1:0]  WINDOW_LENGTH_ADDR = '0;
  localparam logic [COUNT_BITS-1:0] DEFAULT_WINDOW     = 16'd4800;
  localparam logic [COUNT_BITS-1:0] LONGEST_WINDOW     = '1;
  localparam longint unsigned       SUM_CAP = (64'd1 << SUM_BITS) - 1;
  localparam longint unsigned       RMS_CAP = (64'd1 << RMS_BITS) - 1;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] MINUS_ONE  = '1;
  localparam logic [SAMPLE_BITS-1:0] PLUS_ONE   = SAMPLE_BITS'(1);
  localparam logic [SAMPLE_BITS-1:0] CHECKER_A  = {(SAMPLE_BITS / 2){2'b01}};
  localparam logic [SAMPLE_BITS-1:0] CHECKER_B  = {(SAMPLE_BITS / 2){2'b10}};

  // Every input of the block starts at a known value.
  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [ADDR_BITS-1:0]  paddr   = '0;
  logic [DATA_BITS-1:0]  pwdata  = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;
  logic                  push    = 1'b0;
  frame_t                frame   = '0;
  logic                  full;
  logic                  pop     = 1'b0;
  result_t               result;
  logic                  empty;

  dual_block_rms_meter dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push    (push),
    .frame   (frame),
    .full    (full),
    .pop     (pop),
    .result  (result),
    .empty   (empty)
  );

  always begin
    #CLK_HIGH_NS clk = 1'b1;
    #CLK_LOW_NS clk = 1'b0;
  end

  // Frame requests waiting to be sent, and the level results still owed.
  frame_t  frame_queue[$];
  result_t expected_levels[$];

  // Running state of the meter as the testbench sees it.
  logic [COUNT_BITS-1:0] window_len = DEFAULT_WINDOW;
  logic [COUNT_BITS-1:0] frames_in_window = '0;
  longint unsigned       in_energy  = 0;
  longint unsigned       out_energy = 0;

  int frames_queued    = 0;
  int frames_taken     = 0;
  int levels_seen      = 0;
  int settings_written = 0;
  int fault_count      = 0;

  // Idle rates in percent per decision; a rate of zero gives a stretch with no idling.
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int send_gap = 0;
  int take_gap = 0;

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("%s", what);
    end
  endtask

  // Square of a two's complement sample; full-scale negative squares to 2^46.
  function automatic longint unsigned square_of(input logic [SAMPLE_BITS-1:0] raw);
    longint s;
    s = longint'($signed(raw));
    if (s < 0) begin
      s = -s;
    end
    return longint'(s * s);
  endfunction

  function automatic longint unsigned accumulate(input longint unsigned sum,
                                                 input longint unsigned sq);
    return (sum + sq > SUM_CAP) ? SUM_CAP : sum + sq;
  endfunction

  // Largest r with r*r <= x, found by bisection; x is below 2^62.
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'd1 << 31;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= x) begin
        lo = mid;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  // Root of the mean square, aligned to RMS_BITS and clipped at the top code.
  function automatic logic [RMS_BITS-1:0] level_of(input longint unsigned sum,
                                                   input longint unsigned frames);
    longint unsigned r;
    r = floor_root(sum / frames);
    if (SAMPLE_BITS - 1 > RMS_BITS) begin
      r = r >> (SAMPLE_BITS - 1 - RMS_BITS);
    end else begin
      r = r << (RMS_BITS - (SAMPLE_BITS - 1));
    end
    if (r > RMS_CAP) begin
      r = RMS_CAP;
    end
    return RMS_BITS'(r);
  endfunction

  // Fold one accepted frame into the sums. When the window is complete (or
  // was cut below the frames already taken) the owed result is queued and
  // the window starts over. A window length of zero behaves as one.
  task automatic meter_frame(input frame_t f);
    longint unsigned taken;
    longint unsigned target;
    result_t         lv;
    in_energy  = accumulate(in_energy, square_of(f.in_sample));
    out_energy = accumulate(out_energy, square_of(f.out_sample));
    taken  = longint'(frames_in_window) + 1;
    target = (window_len == 0) ? 1 : longint'(window_len);
    if (taken < target) begin
      frames_in_window = COUNT_BITS'(taken);
    end else begin
      lv.in_rms  = level_of(in_energy, taken);
      lv.out_rms = level_of(out_energy, taken);
      expected_levels.push_back(lv);
      frames_in_window = '0;
      in_energy  = 0;
      out_energy = 0;
    end
  endtask

  // Driver: sends frame requests from the queue, holds a request while full
  // is high, and throws in short idle bursts between requests.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        meter_frame(frame);
        frames_taken++;
      end
      if (!(push && full)) begin
        if (send_gap == 0 && frame_queue.size() != 0 &&
            $urandom_range(0, 99) < sender_idle_pct) begin
          send_gap = $urandom_range(1, 3);
        end
        if (send_gap != 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (frame_queue.size() != 0) begin
          frame <= frame_queue.pop_front();
          push  <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes level results, checks each against the oldest one owed,
  // and stalls the block now and then by holding pop low.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        levels_seen++;
        if (expected_levels.size() == 0) begin
          report_fault($sformatf("unexpected level result: in_rms %0d out_rms %0d",
                                 result.in_rms, result.out_rms));
        end else begin
          if (result.in_rms !== expected_levels[0].in_rms ||
              result.out_rms !== expected_levels[0].out_rms) begin
            report_fault($sformatf(
              "level result %0d: expected in_rms %0d out_rms %0d, got %0d %0d",
              levels_seen, expected_levels[0].in_rms, expected_levels[0].out_rms,
              result.in_rms, result.out_rms));
          end
          void'(expected_levels.pop_front());
        end
      end
      if (take_gap == 0 && $urandom_range(0, 99) < receiver_idle_pct) begin
        take_gap = $urandom_range(1, 3);
      end
      if (take_gap != 0) begin
        take_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Wait until every queued frame has been taken and every owed result has
  // come back, then give the back end time to finish any work in flight.
  task automatic settle();
    while (frames_taken != frames_queued || expected_levels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Read the window length back and compare it with the value last written.
  task automatic check_window_reg();
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= WINDOW_LENGTH_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    if (prdata[COUNT_BITS-1:0] !== window_len) begin
      report_fault($sformatf("window_length reads %0d, expected %0d",
                             prdata[COUNT_BITS-1:0], window_len));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the window length. The upper data bits carry noise, which the
  // register must drop.
  task automatic set_window(input logic [COUNT_BITS-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= WINDOW_LENGTH_ADDR;
    pwdata  <= ($urandom() & ~32'h0000_FFFF) | DATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!pready);
    window_len = value;
    settings_written++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_window_reg();
  endtask

  task automatic queue_frame(input logic [SAMPLE_BITS-1:0] a,
                             input logic [SAMPLE_BITS-1:0] b);
    frame_t f;
    f.in_sample  = a;
    f.out_sample = b;
    frame_queue.push_back(f);
    frames_queued++;
  endtask

  // Random sample: full-range values half the time, with small values and both
  // full-scale ends mixed in.
  function automatic logic [SAMPLE_BITS-1:0] draw_sample();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        return SAMPLE_MIN;
      end
      1: begin
        return SAMPLE_MAX;
      end
      2, 3: begin
        v = int'($urandom_range(0, 511)) - 256;
        return SAMPLE_BITS'(v);
      end
      default: begin
        return SAMPLE_BITS'($urandom());
      end
    endcase
  endfunction

  task automatic queue_random_frames(input int count);
    for (int i = 0; i < count; i++) begin
      queue_frame(draw_sample(), draw_sample());
    end
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: begin
        return 0;
      end
      1: begin
        return 15;
      end
      default: begin
        return 40;
      end
    endcase
  endfunction

  initial begin
    int                    random_frames;
    int                    span;
    int                    count;
    logic [COUNT_BITS-1:0] w;

    random_frames = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // The window length must come out of reset at its default.
    check_window_reg();

    // A few frames under the default window, then a window of one: the
    // register now sits below the frames already taken, so the next frame
    // closes the window and the sums are divided by the frames actually taken.
    queue_random_frames(5);
    settle();
    set_window(16'd1);

    // With one frame per window every frame gives a result: walk the
    // extremes of both fields and both bit patterns.
    queue_frame('0, '0);
    queue_frame(SAMPLE_MAX, SAMPLE_MAX);
    queue_frame(SAMPLE_MIN, SAMPLE_MIN);
    queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    queue_frame(MINUS_ONE, PLUS_ONE);
    queue_frame(PLUS_ONE, MINUS_ONE);
    queue_frame(CHECKER_A, CHECKER_B);
    queue_frame(CHECKER_B, CHECKER_A);
    queue_frame(SAMPLE_MIN, '0);

    // A window length of zero acts as one.
    settle();
    set_window('0);
    queue_random_frames(3);

    // A window of nothing but full-scale negative input has an RMS of exactly
    // one, which must clip to the top code; full-scale positive lands on it.
    settle();
    set_window(16'd4);
    repeat (4) queue_frame(SAMPLE_MIN, SAMPLE_MAX);

    // Longest window, cut short part way through by a small one.
    sender_idle_pct   = 15;
    receiver_idle_pct = 15;
    settle();
    set_window(LONGEST_WINDOW);
    queue_random_frames(120);
    random_frames += 120;
    settle();
    set_window(16'd3);

    // Random phases: each picks a window length and idle rates, then sends
    // whole windows of random frames, sometimes with a partial window left
    // over that the next setting may cut short. Every change of setting waits
    // for all owed results first, so the sender pauses many times.
    while (random_frames < RANDOM_FRAMES) begin
      case ($urandom_range(0, 9))
        0: begin
          w = 16'd1;
        end
        1: begin
          w = 16'd2;
        end
        2: begin
          w = 16'd3;
        end
        3: begin
          w = COUNT_BITS'($urandom_range(4, 16));
        end
        4: begin
          w = COUNT_BITS'($urandom_range(17, 96));
        end
        5: begin
          w = COUNT_BITS'($urandom_range(97, 300));
        end
        6: begin
          w = '0;
        end
        default: begin
          w = COUNT_BITS'($urandom_range(1, 40));
        end
      endcase
      span  = (w == 0) ? 1 : int'(w);
      count = (span > 100) ? span : span * int'($urandom_range(1, 4));
      if ($urandom_range(0, 3) == 0) begin
        count += int'($urandom_range(1, span));
      end
      if (count > 400) begin
        count = 400;
      end
      settle();
      sender_idle_pct   = pick_idle_pct();
      receiver_idle_pct = pick_idle_pct();
      set_window(w);
      queue_random_frames(count);
      random_frames += count;
    end

    // Last stretch runs flat out on both sides.
    settle();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    set_window(16'd2);
    queue_random_frames(TAIL_FRAMES);
    random_frames += TAIL_FRAMES;
    settle();

    if (expected_levels.size() != 0) begin
      report_fault($sformatf("%0d level results never arrived", expected_levels.size()));
    end
    $display("Sent %0d frame requests and checked %0d level results over %0d window settings,",
             frames_taken, levels_seen, settings_written);
    $display("including window lengths 0, 1 and 65535 and full-scale samples on both sides.");
    if (fault_count == 0) begin
      $display("dual_block_rms_meter verification clean");
    end else begin
      $display("%0d mismatches in total", fault_count);
      $display("dual_block_rms_meter verification failed");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #RUN_LIMIT_NS;
    $display("dual_block_rms_meter verification failed");
    $finish;
  end

endmodule
